// ===== hdl/kmc_pkg.sv =====
// Shared constants and types of the k-means clustering unit.
package kmc_pkg;

    localparam int FEAT_W   = 16;
    localparam int NUM_FEAT = 4;
    localparam int LBL_W    = 3;
    localparam int IDX_W    = 5;
    localparam int SQ_W     = 32;
    localparam int DIST_W   = 34;

    localparam int DEF_MAX_SAMPLES  = 32;
    localparam int DEF_MAX_CLUSTERS = 8;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LABEL  = 2'd0;
    localparam t_kind KIND_CENTER = 2'd1;
    localparam t_kind KIND_ERROR  = 2'd2;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_NUM_CLUSTERS = 2'd0;
    localparam t_reg_idx REG_NUM_DIMS     = 2'd1;
    localparam t_reg_idx REG_PASS_LIMIT   = 2'd2;

    localparam logic [3:0] RST_NUM_CLUSTERS = 4'd2;
    localparam logic [2:0] RST_NUM_DIMS     = 3'd4;
    localparam logic [7:0] RST_PASS_LIMIT   = 8'd100;

endpackage

// ===== hdl/kmc_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module kmc_divider #(
    parameter int SUM_W = 21,
    parameter int CNT_W = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic        [CNT_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;

    logic [CNT_W:0]    w_trial;
    logic              w_fit;
    logic [CNT_W:0]    w_diff;
    logic [SUM_W-1:0]  w_mag;

    assign w_mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_q    <= w_mag;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[SUM_W-1];
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_q    <= {r_q[SUM_W-2:0], w_fit};
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(SUM_W'(-r_q)) : $signed(r_q);

endmodule

// ===== hdl/kmeans_clustering_unit.sv =====
// Top level of the k-means clustering unit: sample load, Lloyd passes, result stream.
//
// Samples arrive on the slave stream, one transaction per cycle: tdata holds the
// four Q8.8 features, tuser the seed selector (0 none, j+1 seeds center j) and tlast
// marks the final sample of a load. The transaction with tlast closes the load and
// the slave side drops tready for the whole clustering run.
// Each pass assigns every sample to its nearest center, then accumulates the
// per-cluster sums and takes the means with the iterative divider. At most the
// configured pass limit of passes run, and a pass with no label change ends the run.
// Results leave on the master stream through one output register: n label
// transactions, then k center transactions, the last with tlast set. A run with
// fewer samples than clusters gives one error transaction instead. When the receiver
// stalls, the sequencer holds in place until the register frees up. The user writes
// configuration registers through a plain write port only while idle; the block does
// not enforce it. Synchronous active-low reset returns the registers to their defaults
// and the sequencer to loading; memories are not cleared, only written entries are read.
module kmeans_clustering_unit #(
    parameter int MAX_SAMPLES  = kmc_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // Sample stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // feature_0, feature_1, feature_2, feature_3
    input  logic [3:0]  i_s_axis_tuser,  // seed_center
    input  logic        i_s_axis_tlast,  // last_sample
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // item_index, label, coord_0 .. coord_3
    output logic [1:0]  o_m_axis_tuser,  // kind
    output logic        o_m_axis_tlast   // last_result
);

    localparam int FW     = kmc_pkg::FEAT_W;
    localparam int NF     = kmc_pkg::NUM_FEAT;
    localparam int SA_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int SUM_W  = FW + $clog2(MAX_SAMPLES);
    localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_ERR   = 5'd2;
    localparam logic [4:0] S_A_RD  = 5'd3;
    localparam logic [4:0] S_A_LAT = 5'd4;
    localparam logic [4:0] S_A_SQ  = 5'd5;
    localparam logic [4:0] S_A_ACC = 5'd6;
    localparam logic [4:0] S_A_WB  = 5'd7;
    localparam logic [4:0] S_A_END = 5'd8;
    localparam logic [4:0] S_U_CLR = 5'd9;
    localparam logic [4:0] S_U_RD  = 5'd10;
    localparam logic [4:0] S_U_ACC = 5'd11;
    localparam logic [4:0] S_D_CHK = 5'd12;
    localparam logic [4:0] S_D_WT  = 5'd13;
    localparam logic [4:0] S_P_END = 5'd14;
    localparam logic [4:0] S_O_RD  = 5'd15;
    localparam logic [4:0] S_O_LBL = 5'd16;
    localparam logic [4:0] S_O_CTR = 5'd17;

    // Configuration registers.
    logic [3:0] r_cfg_k;
    logic [2:0] r_cfg_nd;
    logic [7:0] r_cfg_it;

    // Run control.
    logic [4:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [3:0]       r_k;
    logic [2:0]       r_nd;
    logic [7:0]       r_maxit;
    logic [7:0]       r_pass;
    logic [CNT_W-1:0] r_i;
    logic [3:0]       r_j;
    logic [1:0]       r_d;
    logic             r_changed;
    logic             r_fresh;

    // Datapath registers.
    logic signed [FW-1:0]    r_samp [NF];
    logic [kmc_pkg::LBL_W-1:0] r_lbl;
    logic [kmc_pkg::LBL_W-1:0] r_bj;
    logic [kmc_pkg::SQ_W-1:0]  r_sq;
    logic [kmc_pkg::DIST_W-1:0] r_dist;
    logic [kmc_pkg::DIST_W-1:0] r_best;
    logic signed [FW-1:0]    r_ctr [MAX_CLUSTERS][NF];
    logic signed [SUM_W-1:0] r_sum [MAX_CLUSTERS][NF];
    logic [CNT_W-1:0]        r_cnt [MAX_CLUSTERS];

    // Memories.
    logic [NF*FW-1:0]          smp_mem [MAX_SAMPLES];
    logic [NF*FW-1:0]          r_smp_q;
    logic [kmc_pkg::LBL_W-1:0] lbl_mem [MAX_SAMPLES];
    logic [kmc_pkg::LBL_W-1:0] r_lbl_q;

    // Output register.
    logic        r_ovalid;
    logic [71:0] r_odata;
    logic [1:0]  r_ouser;
    logic        r_olast;

    logic w_in_acc;
    logic w_smp_we;
    logic w_lbl_we;
    logic w_out_free;
    logic w_out_load;
    logic w_div_start;
    logic w_div_done;
    logic signed [SUM_W-1:0] w_quot;
    logic signed [FW:0]      w_df;
    logic signed [2*FW+1:0]  w_prod;
    logic [kmc_pkg::DIST_W-1:0] w_dsum;
    logic [3:0] w_k_clamp;
    logic [2:0] w_nd_clamp;
    logic [CL_W-1:0] w_jx;
    logic [CL_W-1:0] w_lx;
    logic w_j_last;
    logic w_d_last;
    logic w_i_last;

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_smp_we        = w_in_acc && (r_count < CNT_W'(MAX_SAMPLES));
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign w_out_load      = w_out_free && ((r_state == S_ERR) || (r_state == S_O_LBL) ||
                                            (r_state == S_O_CTR));
    assign w_lbl_we        = (r_state == S_A_WB) && (r_fresh || (r_bj != r_lbl));
    assign w_jx            = r_j[CL_W-1:0];
    assign w_lx            = r_lbl_q[CL_W-1:0];
    assign w_j_last        = (r_j == r_k - 4'd1);
    assign w_d_last        = (r_d == 2'(r_nd - 3'd1));
    assign w_i_last        = (r_i == r_count - CNT_W'(1));
    assign w_div_start     = (r_state == S_D_CHK) && (r_cnt[w_jx] != '0);

    assign w_k_clamp  = (r_cfg_k == 4'd0) ? 4'd1 :
                        (r_cfg_k > 4'(MAX_CLUSTERS)) ? 4'(MAX_CLUSTERS) : r_cfg_k;
    assign w_nd_clamp = (r_cfg_nd == 3'd0) ? 3'd1 :
                        (r_cfg_nd > 3'(NF)) ? 3'(NF) : r_cfg_nd;

    // Squared difference of one feature against one center, then the running sum.
    assign w_df   = {r_samp[r_d][FW-1], r_samp[r_d]} - {r_ctr[w_jx][r_d][FW-1], r_ctr[w_jx][r_d]};
    assign w_prod = w_df * w_df;
    assign w_dsum = r_dist + kmc_pkg::DIST_W'(r_sq);

    kmc_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum[w_jx][r_d]),
        .i_divisor  (r_cnt[w_jx]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Sample memory: written during load, read one entry per cycle at the sample pointer.
    always_ff @(posedge i_clk) begin
        if (w_smp_we) begin
            smp_mem[r_count[SA_W-1:0]] <= i_s_axis_tdata;
        end
        r_smp_q <= smp_mem[r_i[SA_W-1:0]];
    end

    // Label memory: the write of one sample never meets its own read in the same pass.
    always_ff @(posedge i_clk) begin
        if (w_lbl_we) begin
            lbl_mem[r_i[SA_W-1:0]] <= r_bj;
        end
        r_lbl_q <= lbl_mem[r_i[SA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k  <= kmc_pkg::RST_NUM_CLUSTERS;
            r_cfg_nd <= kmc_pkg::RST_NUM_DIMS;
            r_cfg_it <= kmc_pkg::RST_PASS_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                kmc_pkg::REG_NUM_CLUSTERS: r_cfg_k  <= i_cfg_wdata[3:0];
                kmc_pkg::REG_NUM_DIMS:     r_cfg_nd <= i_cfg_wdata[2:0];
                kmc_pkg::REG_PASS_LIMIT:   r_cfg_it <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Center seeding during load: the first sample clears every center it does not seed.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int j = 0; j < MAX_CLUSTERS; j++) begin
                for (int d = 0; d < NF; d++) begin
                    if (w_smp_we && (i_s_axis_tuser == 4'(j + 1))) begin
                        r_ctr[j][d] <= i_s_axis_tdata[d*FW +: FW];
                    end else if (r_count == '0) begin
                        r_ctr[j][d] <= '0;
                    end
                end
            end
        end else if ((r_state == S_D_WT) && w_div_done) begin
            r_ctr[w_jx][r_d] <= w_quot[FW-1:0];
        end
    end

    // Per-cluster sums and member counts of the update pass.
    always_ff @(posedge i_clk) begin
        if (r_state == S_U_CLR) begin
            for (int j = 0; j < MAX_CLUSTERS; j++) begin
                r_cnt[j] <= '0;
                for (int d = 0; d < NF; d++) begin
                    r_sum[j][d] <= '0;
                end
            end
        end else if (r_state == S_U_ACC) begin
            r_cnt[w_lx] <= r_cnt[w_lx] + CNT_W'(1);
            for (int d = 0; d < NF; d++) begin
                r_sum[w_lx][d] <= r_sum[w_lx][d] + SUM_W'($signed(r_smp_q[d*FW +: FW]));
            end
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_fresh   <= 1'b0;
            r_changed <= 1'b0;
            r_pass    <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_d       <= '0;
            r_k       <= 4'd1;
            r_nd      <= 3'd1;
            r_maxit   <= '0;
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_smp_we) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (w_in_acc && i_s_axis_tlast) begin
                        r_k     <= w_k_clamp;
                        r_nd    <= w_nd_clamp;
                        r_maxit <= r_cfg_it;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_pass    <= '0;
                    r_fresh   <= 1'b1;
                    r_changed <= 1'b0;
                    r_i       <= '0;
                    if (CMP_W'(r_count) < CMP_W'(r_k)) begin
                        r_state <= S_ERR;
                    end else if (r_maxit == '0) begin
                        r_state <= S_O_RD;
                    end else begin
                        r_state <= S_A_RD;
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_ouser  <= kmc_pkg::KIND_ERROR;
                        r_odata  <= '0;
                        r_olast  <= 1'b1;
                        r_count  <= '0;
                        r_state  <= S_LOAD;
                    end
                end
                S_A_RD: r_state <= S_A_LAT;
                S_A_LAT: begin
                    for (int d = 0; d < NF; d++) begin
                        r_samp[d] <= r_smp_q[d*FW +: FW];
                    end
                    r_lbl   <= r_fresh ? '0 : r_lbl_q;
                    r_j     <= '0;
                    r_d     <= '0;
                    r_dist  <= '0;
                    r_state <= S_A_SQ;
                end
                S_A_SQ: begin
                    r_sq    <= w_prod[kmc_pkg::SQ_W-1:0];
                    r_state <= S_A_ACC;
                end
                S_A_ACC: begin
                    if (w_d_last) begin
                        if ((r_j == '0) || (w_dsum < r_best)) begin
                            r_best <= w_dsum;
                            r_bj   <= r_j[kmc_pkg::LBL_W-1:0];
                        end
                        r_dist <= '0;
                        r_d    <= '0;
                        if (w_j_last) begin
                            r_state <= S_A_WB;
                        end else begin
                            r_j     <= r_j + 4'd1;
                            r_state <= S_A_SQ;
                        end
                    end else begin
                        r_dist  <= w_dsum;
                        r_d     <= r_d + 2'd1;
                        r_state <= S_A_SQ;
                    end
                end
                S_A_WB: begin
                    if (r_bj != r_lbl) begin
                        r_changed <= 1'b1;
                    end
                    if (w_i_last) begin
                        r_state <= S_A_END;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_A_RD;
                    end
                end
                S_A_END: begin
                    r_fresh <= 1'b0;
                    r_i     <= '0;
                    r_state <= r_changed ? S_U_CLR : S_O_RD;
                end
                S_U_CLR: r_state <= S_U_RD;
                S_U_RD:  r_state <= S_U_ACC;
                S_U_ACC: begin
                    if (w_i_last) begin
                        r_j     <= '0;
                        r_d     <= '0;
                        r_state <= S_D_CHK;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_U_RD;
                    end
                end
                S_D_CHK: begin
                    if (r_cnt[w_jx] == '0) begin
                        if (w_j_last) begin
                            r_state <= S_P_END;
                        end else begin
                            r_j <= r_j + 4'd1;
                        end
                    end else begin
                        r_state <= S_D_WT;
                    end
                end
                S_D_WT: begin
                    if (w_div_done) begin
                        if (w_d_last) begin
                            r_d <= '0;
                            if (w_j_last) begin
                                r_state <= S_P_END;
                            end else begin
                                r_j     <= r_j + 4'd1;
                                r_state <= S_D_CHK;
                            end
                        end else begin
                            r_d     <= r_d + 2'd1;
                            r_state <= S_D_CHK;
                        end
                    end
                end
                S_P_END: begin
                    r_pass    <= r_pass + 8'd1;
                    r_i       <= '0;
                    r_changed <= 1'b0;
                    r_state   <= ((r_pass + 8'd1) < r_maxit) ? S_A_RD : S_O_RD;
                end
                S_O_RD: r_state <= S_O_LBL;
                S_O_LBL: begin
                    if (w_out_free) begin
                        r_ouser  <= kmc_pkg::KIND_LABEL;
                        r_odata  <= {64'd0, (r_fresh ? 3'd0 : r_lbl_q),
                                     kmc_pkg::IDX_W'(r_i)};
                        r_olast  <= 1'b0;
                        if (w_i_last) begin
                            r_j     <= '0;
                            r_state <= S_O_CTR;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= S_O_RD;
                        end
                    end
                end
                S_O_CTR: begin
                    if (w_out_free) begin
                        r_ouser  <= kmc_pkg::KIND_CENTER;
                        r_olast  <= w_j_last;
                        r_odata[7:0] <= {3'd0, kmc_pkg::IDX_W'(r_j)};
                        for (int d = 0; d < NF; d++) begin
                            r_odata[8 + d*FW +: FW] <= (3'(d) < r_nd) ? r_ctr[w_jx][d] : '0;
                        end
                        if (w_j_last) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_j <= r_j + 4'd1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input taken right after the last sample of a load");

    a_label_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lbl_we |-> (4'(r_bj) < r_k))
        else $error("label written beyond active cluster count");

    a_div_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == S_D_WT))
        else $error("divider started outside the mean update");

endmodule
